FILE: hw/rtl/gmdfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdfs_pkg: shared types and codes of the maze path finder
// Command codes and the direction step tables.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    localparam int unsigned COORD_W = 6;

    // Signed row / column step of direction d: north, east, south, west.
    function automatic logic signed [1:0] dir_dr(input logic [1:0] d);
        case (d)
            2'd0:    dir_dr = -2'sd1;
            2'd2:    dir_dr = 2'sd1;
            default: dir_dr = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] dir_dc(input logic [1:0] d);
        case (d)
            2'd1:    dir_dc = 2'sd1;
            2'd3:    dir_dc = -2'sd1;
            default: dir_dc = 2'sd0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/gmdfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdfs_ram: generic single-port-write, one-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gmdfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/grid_maze_dfs_path_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_finder: depth-first maze path search over a walled grid
// Load, solve and read commands; path cells kept on a stack RAM.
// ----------------------------------------------------------------------------
// Load: takes effect at its accepting edge, no result. Read: passes through
//   ST_RD and ST_RD2 to ST_DONE, which registers the strobe.
// Solve: a clearing sweep over the MAX_ROWS+2 visited-map rows, then per
//   direction ST_EVAL alone for an off-grid probe, ST_EVAL, ST_PROBE and ST_CHECK
//   for a neighbor probe, ST_PUSH to enter, ST_POP and ST_TOP to backtrack; then ST_DONE strobes.
// Throughput: one transaction at a time; busy drops with the result strobe.
// Reset: synchronous active low; rows = cols = 32, no path held. The receiver
//   cannot stall: each result shows for exactly one cycle on o_done.
module grid_maze_dfs_path_finder #(
    parameter int unsigned MAX_ROWS = 32,
    parameter int unsigned MAX_COLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_wall,
    output logic        o_done,
    output logic        o_found,
    output logic [10:0] o_path_length,
    output logic [5:0]  o_step_row,
    output logic [5:0]  o_step_col,
    output logic        o_step_valid,
    output logic        o_step_last
);
    localparam int unsigned GR = MAX_ROWS + 2;
    localparam int unsigned GC = MAX_COLS + 2;
    localparam int unsigned GRAW = $clog2(GR);
    localparam int unsigned SD = MAX_ROWS * MAX_COLS + 1;  // stack entries
    localparam int unsigned SAW = $clog2(SD);
    localparam int unsigned DW = $clog2(SD); // depth counter bits (holds SD-1)
    localparam int unsigned CW = gmdfs_pkg::COORD_W;
    localparam int unsigned SW = 2 * CW + 3;   // row, col, dir (0..4)

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_TOP, ST_EVAL, ST_PROBE, ST_CHECK, ST_PUSH,
        ST_POP, ST_RD, ST_RD2, ST_DONE
    } t_state;

    t_state r_state;
    logic [5:0] r_rows, r_cols;
    logic [DW-1:0] r_top, r_depth, r_rptr;
    logic r_found;
    logic [5:0] r_er, r_ec;
    logic [CW-1:0] r_cr, r_cc, r_gr, r_gc;
    logic [2:0] r_dir;
    logic [GRAW-1:0] r_clr;
    logic r_is_read;

    // Effective dimensions (clamped).
    logic [5:0] w_er, w_ec;
    always_comb begin
        w_er = (r_rows == 6'd0) ? 6'd1 : r_rows;
        if (32'(r_rows) > MAX_ROWS) w_er = 6'(MAX_ROWS);
        w_ec = (r_cols == 6'd0) ? 6'd1 : r_cols;
        if (32'(r_cols) > MAX_COLS) w_ec = 6'(MAX_COLS);
    end

    // Visited map: one row word per address. Stack: one entry per path cell.
    logic           vm_we, st_we;
    logic [GRAW-1:0] vm_waddr, vm_raddr;
    logic [GC-1:0]  vm_wdata, vm_rdata;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [SW-1:0]  st_wdata, st_rdata;

    // Wall map: one bit per cell, so a load needs no read-modify-write.
    localparam int unsigned WAW = $clog2(GR * GC);
    logic [WAW-1:0] wb_waddr, wb_raddr;
    logic [0:0] wb_rdata;
    logic wb_we;

    gmdfs_ram #(.WIDTH(1), .DEPTH(GR * GC)) u_wall (
        .i_clk(i_clk), .i_we(wb_we), .i_waddr(wb_waddr), .i_wdata(i_wall),
        .i_raddr(wb_raddr), .o_rdata(wb_rdata)
    );
    gmdfs_ram #(.WIDTH(GC), .DEPTH(GR)) u_visit (
        .i_clk(i_clk), .i_we(vm_we), .i_waddr(vm_waddr), .i_wdata(vm_wdata),
        .i_raddr(vm_raddr), .o_rdata(vm_rdata)
    );
    gmdfs_ram #(.WIDTH(SW), .DEPTH(SD)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    logic w_acc;
    assign w_acc = start && !busy;
    assign busy  = (r_state != ST_IDLE);

    // Neighbor of current cell in direction r_dir.
    logic signed [CW+1:0] w_ng, w_nh;
    logic w_off;
    always_comb begin
        w_ng = $signed({2'b00, r_cr}) + (CW+2)'(gmdfs_pkg::dir_dr(r_dir[1:0]));
        w_nh = $signed({2'b00, r_cc}) + (CW+2)'(gmdfs_pkg::dir_dc(r_dir[1:0]));
        w_off = (w_ng < 0) || (w_nh < 0) || (w_ng > $signed({2'b00, r_er}) + 1)
             || (w_nh > $signed({2'b00, r_ec}) + 1);
    end

    logic w_ld_ok;
    assign w_ld_ok = (32'(i_cell_row) < GR) && (32'(i_cell_col) < GC);

    always_comb begin
        wb_we    = w_acc && (gmdfs_pkg::t_cmd'(i_command) == gmdfs_pkg::CMD_LOAD) && w_ld_ok;
        wb_waddr = WAW'(32'(i_cell_row) * GC + 32'(i_cell_col));
        wb_raddr = WAW'(32'(r_gr) * GC + 32'(r_gc));
        vm_we    = 1'b0;
        vm_waddr = GRAW'(r_gr);
        vm_wdata = vm_rdata | (GC'(1) << r_gc);
        vm_raddr = GRAW'(r_gr);
        st_we    = 1'b0;
        st_waddr = SAW'(r_top);
        st_wdata = {r_cr, r_cc, r_dir};
        st_raddr = SAW'(r_top);
        case (r_state)
            ST_CLEAR: begin
                vm_we    = 1'b1;
                vm_waddr = r_clr;
                vm_wdata = (r_clr == GRAW'(1)) ? GC'(2) : '0;
            end
            ST_EVAL: begin
                // save advanced direction of current entry
                st_we    = (r_dir != 3'd4);
                st_wdata = {r_cr, r_cc, r_dir + 3'd1};
            end
            ST_PUSH: begin
                vm_we    = 1'b1;
                st_we    = 1'b1;
                st_waddr = SAW'(r_top + DW'(1));
                st_wdata = {r_gr, r_gc, 3'd0};
            end
            ST_POP: st_raddr = SAW'(r_top - DW'(1));
            // hold the path address so the data is still there at ST_DONE
            ST_RD, ST_RD2: st_raddr = SAW'(r_rptr + DW'(1));
            default: ;
        endcase
    end

    logic w_wall_cell;
    assign w_wall_cell = wb_rdata[0];

    logic w_step;
    assign w_step = r_is_read && r_found && (r_rptr < r_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rows <= 6'd32; r_cols <= 6'd32;
            r_depth <= '0; r_rptr <= '0; r_found <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == gmdfs_pkg::REG_ROWS) r_rows <= i_cfg_data;
                else r_cols <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: if (w_acc) begin
                    case (gmdfs_pkg::t_cmd'(i_command))
                        gmdfs_pkg::CMD_SOLVE: begin
                            r_er <= w_er; r_ec <= w_ec;
                            r_clr <= '0; r_found <= 1'b0;
                            r_depth <= '0; r_rptr <= '0;
                            r_state <= ST_CLEAR;
                        end
                        gmdfs_pkg::CMD_READ: begin
                            r_is_read <= 1'b1;
                            r_state <= ST_RD;
                        end
                        default: ;
                    endcase
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + GRAW'(1);
                    if (32'(r_clr) == GR - 1) begin
                        r_top <= '0; r_cr <= CW'(1); r_cc <= CW'(1); r_dir <= '0;
                        r_state <= ST_EVAL;
                    end
                end
                ST_TOP: begin   // stack read data valid
                    {r_cr, r_cc, r_dir} <= st_rdata;
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (r_cr == r_er && r_cc == r_ec) begin
                        r_found <= 1'b1; r_depth <= r_top;
                        r_is_read <= 1'b0; r_state <= ST_DONE;
                    end else if (r_dir != 3'd4) begin
                        r_dir <= r_dir + 3'd1;
                        if (w_off) r_state <= ST_EVAL;
                        else begin
                            r_gr <= CW'(w_ng); r_gc <= CW'(w_nh);
                            r_state <= ST_PROBE;
                        end
                    end else if (r_top == '0) begin
                        r_is_read <= 1'b0; r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_POP;
                    end
                end
                ST_PROBE: r_state <= ST_CHECK;   // wall/visit reads in flight
                ST_CHECK: begin
                    if (w_wall_cell || vm_rdata[r_gc] || 32'(r_top) >= SD - 1)
                        r_state <= ST_EVAL;
                    else r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    r_top <= r_top + DW'(1);
                    r_cr <= r_gr; r_cc <= r_gc; r_dir <= '0;
                    r_state <= ST_EVAL;
                end
                ST_POP: begin
                    r_top <= r_top - DW'(1);
                    r_state <= ST_TOP;
                end
                ST_RD: r_state <= ST_RD2;
                ST_RD2: r_state <= ST_DONE;
                ST_DONE: begin
                    // result payload registered with the strobe
                    o_done        <= 1'b1;
                    o_found       <= r_found;
                    o_path_length <= 11'(r_depth);
                    o_step_valid  <= w_step;
                    o_step_row    <= w_step ? st_rdata[SW-1 -: CW] : '0;
                    o_step_col    <= w_step ? st_rdata[3 +: CW] : '0;
                    o_step_last   <= w_step && (r_rptr + DW'(1) == r_depth);
                    if (w_step)
                        r_rptr <= r_rptr + DW'(1);
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_found || o_path_length == 11'd0))
        else $error("path length without a path");
    a_step_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_step_valid) |-> o_found)
        else $error("step returned without a path");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_step_last) |-> o_step_valid)
        else $error("last without valid step");
    a_rptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rptr <= r_depth)
        else $error("read pointer past path end");
`endif
endmodule
